/* hw/rtl/tcit_pkg.sv */
// shared types and constants for the interval timer
package tcit_pkg;
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TIME  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_WIDE = 2'd3
  } size_t_t;

  typedef enum logic [1:0] {
    KIND_CTRL   = 2'd0,
    KIND_PRESET = 2'd1,
    KIND_COUNT  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_RATE    = 2'd1;
  localparam logic [1:0] MODE_SQUARE  = 2'd2;

  localparam logic [0:0] CFG_TICK_PERIOD = 1'b0;
  localparam logic [0:0] CFG_CTRL_MASK   = 1'b1;

  localparam logic [31:0] TICK_PERIOD_RST = 32'd1000000;
  localparam logic [31:0] CTRL_MASK_RST   = 32'd7;
  localparam logic [31:0] CLEAR_ENABLE    = 32'hFFFF_FFFE;

  // classified operation handed from front to back
  typedef struct packed {
    logic        is_read;
    logic        is_write;
    logic        is_tick;
    logic [2:0]  chan;
    kind_t       kind;
    logic [31:0] lane_mask;
    logic [31:0] lane_data;
    logic [1:0]  size;
    logic [1:0]  lane;
  } op_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  irq_pulses;
  } result_t;
endpackage

/* hw/rtl/tcit_if.sv */
// input and result channel interfaces
interface tcit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  bus_address;
  logic [1:0]  access_size;
  logic [31:0] write_data;
  logic [31:0] elapsed_ns;
  modport source (output valid, opcode, bus_address, access_size, write_data, elapsed_ns,
                  input ready);
  modport sink (input valid, opcode, bus_address, access_size, write_data, elapsed_ns,
                output ready);
endinterface

interface tcit_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  irq_pulses;
  modport source (output valid, read_data, irq_pulses, input ready);
  modport sink (input valid, read_data, irq_pulses, output ready);
endinterface

/* hw/rtl/tcit_front.sv */
// front end: decodes items, runs the nanosecond accumulator, feeds the queue
module tcit_front #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_bus_address,
  input  logic [1:0]          in_access_size,
  input  logic [31:0]         in_write_data,
  input  logic [31:0]         in_elapsed_ns,
  input  logic [31:0]         tick_period,
  input  logic                q_ready,
  output logic                q_valid,
  output tcit_pkg::op_t       q_op
);
  logic [31:0] acc_r, acc_nxt;
  logic [32:0] sum;
  logic [5:0]  reg_sel;
  logic [5:0]  chan6;
  logic [1:0]  kind2;
  logic [31:0] m, d;
  logic        hit, fire, take;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign take     = in_valid && q_ready;

  assign reg_sel = in_bus_address[7:2];
  // select / 3 over six bits via reciprocal multiply
  assign chan6 = 6'((12'(reg_sel) * 12'd43) >> 7);
  assign kind2 = 2'(reg_sel - 6'(chan6 * 6'd3));
  assign hit   = 32'(chan6) < 32'(NUM_CHANNELS);

  always_comb begin
    case (tcit_pkg::size_t_t'(in_access_size))
      tcit_pkg::SZ_BYTE: begin
        m = 32'hFF << {in_bus_address[1:0], 3'b000};
        d = {24'd0, in_write_data[7:0]} << {in_bus_address[1:0], 3'b000};
      end
      tcit_pkg::SZ_HALF: begin
        m = 32'hFFFF << {in_bus_address[1], 4'b0000};
        d = {16'd0, in_write_data[15:0]} << {in_bus_address[1], 4'b0000};
      end
      default: begin
        m = 32'hFFFF_FFFF;
        d = in_write_data;
      end
    endcase
  end

  assign sum  = {1'b0, acc_r} + {1'b0, in_elapsed_ns};
  assign fire = sum[31:0] > tick_period;

  always_comb begin
    acc_nxt = acc_r;
    if (take && in_opcode == tcit_pkg::OP_TIME)
      acc_nxt = fire ? sum[31:0] - tick_period : sum[31:0];
  end

  always_comb begin
    q_op           = '0;
    q_op.is_read   = in_opcode == tcit_pkg::OP_READ && hit;
    q_op.is_write  = in_opcode == tcit_pkg::OP_WRITE && hit;
    q_op.is_tick   = in_opcode == tcit_pkg::OP_TIME && fire;
    q_op.chan      = chan6[2:0];
    q_op.kind      = tcit_pkg::kind_t'(kind2);
    q_op.lane_mask = m;
    q_op.lane_data = d;
    q_op.size      = in_access_size;
    q_op.lane      = in_bus_address[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end
endmodule

/* hw/rtl/tcit_queue.sv */
// two-entry queue between front and back
module tcit_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tcit_pkg::op_t wr_op,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tcit_pkg::op_t rd_op
);
  tcit_pkg::op_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_op    = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* hw/rtl/tcit_back.sv */
// back end: channel registers, stepping and result register
module tcit_back #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  output logic          op_ready,
  input  tcit_pkg::op_t op,
  input  logic [31:0]   ctrl_mask,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_read_data,
  output logic [2:0]    out_irq_pulses
);
  logic [31:0] ctrl_r [NUM_CHANNELS];
  logic [31:0] preset_r [NUM_CHANNELS];
  logic [31:0] count_r [NUM_CHANNELS];
  logic        lvl_r [NUM_CHANNELS];
  logic [31:0] ctrl_nxt [NUM_CHANNELS];
  logic [31:0] count_nxt [NUM_CHANNELS];
  logic        lvl_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] irq;
  logic        valid_r;
  logic [31:0] rdata_r, rdata_nxt, v;
  logic [2:0]  irq_r, irq_nxt;
  logic        go;

  assign op_ready = !valid_r || out_ready;
  assign go       = op_valid && op_ready;
  assign out_valid      = valid_r;
  assign out_read_data  = rdata_r;
  assign out_irq_pulses = irq_r;

  always_comb begin
    logic [31:0] n;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      ctrl_nxt[c]  = ctrl_r[c];
      count_nxt[c] = count_r[c];
      lvl_nxt[c]   = lvl_r[c];
      irq[c]       = 1'b0;
      n            = count_r[c];
      if (ctrl_r[c][0]) begin
        case (ctrl_r[c][2:1])
          tcit_pkg::MODE_ONESHOT: begin
            if (n != 0) begin
              lvl_nxt[c] = 1'b0;
              n = n - 32'd1;
            end
            if (n == 0) begin
              lvl_nxt[c]  = 1'b1;
              irq[c]      = 1'b1;
              ctrl_nxt[c] = ctrl_r[c] & tcit_pkg::CLEAR_ENABLE;
            end
          end
          tcit_pkg::MODE_RATE: begin
            n = n - 32'd1;
            if (n == 0) begin
              lvl_nxt[c] = 1'b0;
              n = preset_r[c];
            end else if (!lvl_r[c]) begin
              lvl_nxt[c] = 1'b1;
              irq[c]     = 1'b1;
            end
          end
          tcit_pkg::MODE_SQUARE: begin
            if (n[0]) n = n - (lvl_r[c] ? 32'd1 : 32'd3);
            else n = n - 32'd2;
            if (n == 0) begin
              n = preset_r[c];
              lvl_nxt[c] = !lvl_r[c];
              irq[c]     = !lvl_r[c];
            end
          end
          default: ;
        endcase
      end
      count_nxt[c] = n;
    end
  end

  // register read with lane alignment, and interrupt pulses on ticks
  always_comb begin
    v = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (op.chan == 3'(c)) begin
        case (op.kind)
          tcit_pkg::KIND_CTRL:   v = ctrl_r[c];
          tcit_pkg::KIND_PRESET: v = preset_r[c];
          default:               v = count_r[c];
        endcase
      end
    end
    rdata_nxt = '0;
    irq_nxt   = '0;
    if (op.is_read) begin
      case (tcit_pkg::size_t_t'(op.size))
        tcit_pkg::SZ_BYTE: rdata_nxt = (v >> {op.lane, 3'b000}) & 32'hFF;
        tcit_pkg::SZ_HALF: rdata_nxt = (v >> {op.lane[1], 4'b0000}) & 32'hFFFF;
        default:           rdata_nxt = v;
      endcase
    end
    if (op.is_tick) begin
      for (int c = 0; c < NUM_CHANNELS && c < 3; c++) irq_nxt[c] = irq[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ctrl_r[c]   <= '0;
        preset_r[c] <= '0;
        count_r[c]  <= '0;
        lvl_r[c]    <= 1'b0;
      end
    end else begin
      if (go) begin
        valid_r <= 1'b1;
        rdata_r <= rdata_nxt;
        irq_r   <= irq_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (go && op.is_tick) begin
          ctrl_r[c]  <= ctrl_nxt[c];
          count_r[c] <= count_nxt[c];
          lvl_r[c]   <= lvl_nxt[c];
        end else if (go && op.is_write && op.chan == 3'(c)) begin
          case (op.kind)
            tcit_pkg::KIND_CTRL: begin
              ctrl_r[c] <= ((ctrl_r[c] & ~op.lane_mask) | (op.lane_data & op.lane_mask))
                           & ctrl_mask;
              if ((((ctrl_r[c] & ~op.lane_mask) | (op.lane_data & op.lane_mask))
                   & ctrl_mask & 32'd1) != 0)
                count_r[c] <= preset_r[c];
            end
            tcit_pkg::KIND_PRESET:
              preset_r[c] <= (preset_r[c] & ~op.lane_mask) | (op.lane_data & op.lane_mask);
            default:
              count_r[c] <= (count_r[c] & ~op.lane_mask) | (op.lane_data & op.lane_mask);
          endcase
        end
      end
    end
  end
endmodule

/* hw/rtl/three_channel_interval_timer.sv */
// top level: three-channel interval timer with decoupled decode and execute
// Each item (bus read, bus write or elapsed time) yields one result item. The front end
// decodes the address and updates the nanosecond accumulator in the accept cycle; a
// two-entry queue feeds the back end, which updates all channels in parallel and holds
// the result in an output register. One item per cycle is sustained while the result
// channel is ready; an accepted item is written into a queue entry, and the result
// register loads when the back end takes the item from the queue. Configuration writes
// apply on the edge they are taken.
module three_channel_interval_timer #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  tcit_in_if.sink     in_ch,
  tcit_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0]   period_r, mask_r;
  logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  tcit_pkg::op_t q_in_op, q_out_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= tcit_pkg::TICK_PERIOD_RST;
      mask_r   <= tcit_pkg::CTRL_MASK_RST;
    end else if (cfg_we) begin
      if (cfg_index == tcit_pkg::CFG_TICK_PERIOD) period_r <= cfg_data;
      if (cfg_index == tcit_pkg::CFG_CTRL_MASK) mask_r <= cfg_data;
    end
  end

  tcit_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_opcode(in_ch.opcode), .in_bus_address(in_ch.bus_address),
    .in_access_size(in_ch.access_size), .in_write_data(in_ch.write_data),
    .in_elapsed_ns(in_ch.elapsed_ns), .tick_period(period_r),
    .q_ready(q_in_ready), .q_valid(q_in_valid), .q_op(q_in_op)
  );

  tcit_queue u_queue (
    .clk, .rst_n,
    .wr_valid(q_in_valid), .wr_ready(q_in_ready), .wr_op(q_in_op),
    .rd_valid(q_out_valid), .rd_ready(q_out_ready), .rd_op(q_out_op)
  );

  tcit_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk, .rst_n,
    .op_valid(q_out_valid), .op_ready(q_out_ready), .op(q_out_op),
    .ctrl_mask(mask_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_read_data(out_ch.read_data), .out_irq_pulses(out_ch.irq_pulses)
  );

  // the read data of a held result must not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.read_data))
    else $error("result changed while stalled");
  // interrupts only with zero read data
  a_irq_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.irq_pulses != 0 |-> out_ch.read_data == 0)
    else $error("irq with read data");
  // an item that the back end takes from the queue shows up as a valid result
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_out_valid && q_out_ready |=> out_ch.valid)
    else $error("item lost between queue and result register");
endmodule
